/* rtl/gaussian_weighted_score_accumulator_defines.svh */
// Assertion macros for the gaussian weighted score accumulator.
`ifndef GAUSSIAN_WEIGHTED_SCORE_ACCUMULATOR_DEFINES_SVH
`define GAUSSIAN_WEIGHTED_SCORE_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define GWSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gwsa assertion failed");
// Next-cycle implication, checked out of reset.
`define GWSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gwsa assertion failed");
`else
`define GWSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GWSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/gwsa_pkg.sv */
// Shared types, constants and the exp table generator for the score accumulator.
package gwsa_pkg;

  typedef struct packed {
    logic               kind;
    logic [15:0]        point_index;
    logic signed [15:0] h_angle;
    logic signed [15:0] v_angle;
    logic [23:0]        distance;
    logic signed [31:0] signal_value;
  } gwsa_in_t;

  typedef struct packed {
    logic [15:0]        index_out;
    logic signed [47:0] contribution;
    logic signed [47:0] score;
    logic               inside_res;
    logic               zero_distance;
    logic               saturated;
  } gwsa_out_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic mul1;
    logic mul2;
    logic sum;
    logic arg;
    logic tidx;
    logic rom;
    logic gmul;
    logic pmul;
    logic div_start;
    logic mem_rd;
    logic update;
  } gwsa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic contrib_en;
    logic div_done;
  } gwsa_sts_t;

  localparam logic          KIND_ACC  = 1'b0;
  localparam logic          KIND_READ = 1'b1;

  localparam logic [1:0]    CFG_INV_H_SPREAD    = 2'd0;
  localparam logic [1:0]    CFG_INV_V_SPREAD    = 2'd1;
  localparam logic [1:0]    CFG_EXP_COEFFICIENT = 2'd2;
  localparam logic [1:0]    CFG_PEAK_FACTOR     = 2'd3;

  localparam logic [15:0]   RST_INV_H_SPREAD    = 16'd5243;
  localparam logic [15:0]   RST_INV_V_SPREAD    = 16'd8738;
  localparam logic [15:0]   RST_EXP_COEFFICIENT = 16'd3200;
  localparam logic [23:0]   RST_PEAK_FACTOR     = 24'd712040;

  localparam logic signed [47:0] SCORE_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SCORE_MIN = {1'b1, {47{1'b0}}};

  // divider: 40-bit dividend, 24-bit divisor, two quotient bits per cycle
  localparam int DIV_NW    = 40;
  localparam int DIV_DW    = 24;
  localparam int DIV_STEPS = DIV_NW / 2;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [63:0] ONE_Q32 = 64'd4294967296;

  function automatic logic [63:0] div_small(input logic [63:0] a, input int k);
    logic [63:0] q;
    unique case (k)
      1:  q = a;
      2:  q = a / 2;
      3:  q = a / 3;
      4:  q = a / 4;
      5:  q = a / 5;
      6:  q = a / 6;
      7:  q = a / 7;
      8:  q = a / 8;
      9:  q = a / 9;
      10: q = a / 10;
      11: q = a / 11;
      12: q = a / 12;
      13: q = a / 13;
      default: q = a;
    endcase
    return q;
  endfunction

  // exp(-t) for t in Q.32, result Q1.24; elaboration time only
  function automatic logic [24:0] exp_neg_q24(input logic [63:0] t);
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [64:0] acc;
    n    = t / LN2_Q32;
    f    = t - n * LN2_Q32;
    term = ONE_Q32;
    acc  = 65'(ONE_Q32);
    for (int k = 1; k <= 13; k++) begin
      term = div_small((term * f) >> 32, k);
      if ((k & 1) != 0) acc = acc - 65'(term);
      else              acc = acc + 65'(term);
    end
    if (acc < 0) acc = '0;
    if (n > 64'd40) return '0;
    v = 64'(acc) >> n;
    return 25'((v + 64'd128) >> 8);
  endfunction

endpackage

/* rtl/gwsa_div.sv */
// Radix-4 restoring divider, two quotient bits per cycle.
module gwsa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gwsa_pkg::DIV_NW-1:0]   num,
  input  logic [gwsa_pkg::DIV_DW-1:0]   den,
  output logic [gwsa_pkg::DIV_NW-1:0]   quo,
  output logic                          done
);
  import gwsa_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              last;

  always_comb begin
    logic [DIV_DW:0] t;
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int s = 0; s < 2; s++) begin
      t       = {rem_nxt, num_nxt[DIV_NW-1]};
      num_nxt = {num_nxt[DIV_NW-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t          = t - {1'b0, den_r};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = t[DIV_DW-1:0];
    end
  end

  assign last = (cnt_r == CW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

/* rtl/gwsa_dp.sv */
// Datapath: config registers, multiplier chain, exp ROM, divider and score memory.
module gwsa_dp #(
  parameter int POINT_COUNT     = 65536,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gwsa_pkg::gwsa_cmd_t  cmd,
  output gwsa_pkg::gwsa_sts_t  sts,
  input  gwsa_pkg::gwsa_in_t   in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  output logic                 out_valid,
  output gwsa_pkg::gwsa_out_t  out_item
);
  import gwsa_pkg::*;

  localparam int AW  = $clog2(POINT_COUNT);
  localparam int TW  = $clog2(EXP_TABLE_DEPTH);
  localparam int DPW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW  = 33 + DPW;

  typedef logic [24:0] rom_t [EXP_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++)
      r[i] = exp_neg_q24((64'(i) << 36) / EXP_TABLE_DEPTH);
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  logic [47:0] mem [POINT_COUNT];

  logic [15:0]        inv_h_r, inv_v_r, coef_r;
  logic [23:0]        peak_r;
  gwsa_in_t           item_r;
  logic [30:0]        ux_r, uy_r;
  logic [61:0]        sqx_r, sqy_r;
  logic               inside_r;
  logic [16:0]        r16_r;
  logic [32:0]        arg_r;
  logic               ti_ok_r;
  logic [TW-1:0]      ti_idx_r;
  logic [24:0]        w_r;
  logic [23:0]        g_r;
  logic [DIV_NW-1:0]  num_r;
  logic signed [47:0] contrib_r;
  logic [47:0]        rd_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               out_valid_r;
  gwsa_out_t          out_r;

  logic signed [32:0] px, py;
  logic [62:0]        r2;
  logic [32:0]        arg;
  logic [PW-1:0]      tprod;
  logic [PW-29:0]     ti;
  logic [48:0]        gprod;
  logic [31:0]        mag;
  logic [55:0]        nprod;
  logic [DIV_NW-1:0]  quo;
  logic               div_done;
  logic [47:0]        qs;
  logic signed [48:0] sum49;
  logic signed [47:0] s;
  logic               sat;
  logic               in_store;
  logic               acc;
  logic [AW-1:0]      addr;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_h_r <= RST_INV_H_SPREAD;
      inv_v_r <= RST_INV_V_SPREAD;
      coef_r  <= RST_EXP_COEFFICIENT;
      peak_r  <= RST_PEAK_FACTOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_H_SPREAD:    inv_h_r <= cfg_data[15:0];
        CFG_INV_V_SPREAD:    inv_v_r <= cfg_data[15:0];
        CFG_EXP_COEFFICIENT: coef_r  <= cfg_data[15:0];
        CFG_PEAK_FACTOR:     peak_r  <= cfg_data;
      endcase
    end
  end

  assign px    = item_r.h_angle * $signed({1'b0, inv_h_r});
  assign py    = item_r.v_angle * $signed({1'b0, inv_v_r});
  assign r2    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign arg   = 33'(coef_r) * 33'(r16_r);
  assign tprod = PW'(arg_r) * PW'(EXP_TABLE_DEPTH);
  assign ti    = tprod[PW-1:28];
  assign gprod = 49'(peak_r) * 49'(w_r);
  assign mag   = item_r.signal_value[31] ? (~item_r.signal_value + 32'd1)
                                         : item_r.signal_value;
  assign nprod = 56'(g_r) * 56'(mag);
  assign qs    = {8'd0, quo};

  assign acc      = (item_r.kind == KIND_ACC);
  assign in_store = (32'(item_r.point_index) < 32'(POINT_COUNT));
  assign addr     = AW'(item_r.point_index);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.mul1) begin
      ux_r <= px[32] ? 31'(-px) : px[30:0];
      uy_r <= py[32] ? 31'(-py) : py[30:0];
    end
    if (cmd.mul2) begin
      sqx_r <= 62'(ux_r) * 62'(ux_r);
      sqy_r <= 62'(uy_r) * 62'(uy_r);
    end
    if (cmd.sum) r16_r <= r2[48:32];
    if (cmd.arg) arg_r <= arg;
    if (cmd.tidx) begin
      ti_ok_r  <= (32'(ti) < 32'(EXP_TABLE_DEPTH));
      ti_idx_r <= ti[TW-1:0];
    end
    if (cmd.rom)  w_r   <= ti_ok_r ? EXP_ROM[ti_idx_r] : '0;
    if (cmd.gmul) g_r   <= gprod[47:24];
    if (cmd.pmul) num_r <= nprod[55:16];
    if (cmd.mem_rd) begin
      if (!sts.contrib_en)             contrib_r <= '0;
      else if (item_r.signal_value[31]) contrib_r <= -$signed(qs);
      else                             contrib_r <= $signed(qs);
    end
  end

  // inside flag is cleared per item so reads report zero
  always_ff @(posedge clk) begin
    if (!rst_n)        inside_r <= 1'b0;
    else if (cmd.load) inside_r <= 1'b0;
    else if (cmd.sum)  inside_r <= (r2 <= 63'h1_0000_0000_0000);
  end

  gwsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (item_r.distance),
    .quo   (quo),
    .done  (div_done)
  );

  // saturating score update
  always_comb begin
    sum49 = {rd_r[47], rd_r} + {contrib_r[47], contrib_r};
    sat   = (sum49[48] != sum49[47]);
    if (!sat)           s = sum49[47:0];
    else if (sum49[48]) s = SCORE_MIN;
    else                s = SCORE_MAX;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr)
      mem[clr_cnt_r] <= '0;
    else if (cmd.update && acc && in_store)
      mem[addr] <= s;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.update;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.index_out     <= item_r.point_index;
      out_r.contribution  <= contrib_r;
      out_r.score         <= !in_store ? '0 : (acc ? s : rd_r);
      out_r.inside_res    <= inside_r;
      out_r.zero_distance <= inside_r && (item_r.distance == '0);
      out_r.saturated     <= acc && in_store && sat;
    end
  end

  assign sts.clr_done   = (clr_cnt_r == AW'(POINT_COUNT - 1));
  assign sts.contrib_en = acc && inside_r && (item_r.distance != '0);
  assign sts.div_done   = div_done;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/gwsa_ctrl.sv */
// Controller FSM sequencing the accumulate and read operations.
module gwsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_kind,
  output logic                 busy,
  output gwsa_pkg::gwsa_cmd_t  cmd,
  input  gwsa_pkg::gwsa_sts_t  sts
);
  import gwsa_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_ARG, ST_TIDX, ST_ROM,
    ST_GMUL, ST_PMUL, ST_DIVS, ST_DIVW, ST_MEMRD, ST_UPD
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: if (sts.clr_done) state_r <= ST_IDLE;
        ST_IDLE: begin
          if (start) state_r <= (in_kind == KIND_READ) ? ST_MEMRD : ST_MUL1;
        end
        ST_MUL1:  state_r <= ST_MUL2;
        ST_MUL2:  state_r <= ST_SUM;
        ST_SUM:   state_r <= ST_ARG;
        ST_ARG:   state_r <= ST_TIDX;
        ST_TIDX:  state_r <= ST_ROM;
        ST_ROM:   state_r <= ST_GMUL;
        ST_GMUL:  state_r <= ST_PMUL;
        ST_PMUL:  state_r <= sts.contrib_en ? ST_DIVS : ST_MEMRD;
        ST_DIVS:  state_r <= ST_DIVW;
        ST_DIVW:  if (sts.div_done) state_r <= ST_MEMRD;
        ST_MEMRD: state_r <= ST_UPD;
        ST_UPD:   state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && start;
    cmd.clr       = (state_r == ST_CLEAR);
    cmd.mul1      = (state_r == ST_MUL1);
    cmd.mul2      = (state_r == ST_MUL2);
    cmd.sum       = (state_r == ST_SUM);
    cmd.arg       = (state_r == ST_ARG);
    cmd.tidx      = (state_r == ST_TIDX);
    cmd.rom       = (state_r == ST_ROM);
    cmd.gmul      = (state_r == ST_GMUL);
    cmd.pmul      = (state_r == ST_PMUL);
    cmd.div_start = (state_r == ST_DIVS);
    cmd.mem_rd    = (state_r == ST_MEMRD);
    cmd.update    = (state_r == ST_UPD);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/gaussian_weighted_score_accumulator.sv */
// Gaussian weighted score accumulator: top level joining controller and datapath.
// An accepted read goes straight to the memory read and update; an accumulate
// walks the multiplier chain and, when it contributes, the divider (20 radix-4
// steps). One item at a time: the next transfer is taken once busy is low again.
// Reset (rst_n low, synchronous) restores config and clears the score memory
// with busy high; out_valid strobes one cycle, no stall.
`include "gaussian_weighted_score_accumulator_defines.svh"
module gaussian_weighted_score_accumulator #(
  parameter int POINT_COUNT     = 65536,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item: a transfer happens when start is high and busy is low
  input  logic                 start,
  output logic                 busy,
  input  gwsa_pkg::gwsa_in_t   in_item,
  // result: one-cycle strobe
  output logic                 out_valid,
  output gwsa_pkg::gwsa_out_t  out_item,
  // configuration writes, taken only while idle: the user must keep to this, the block itself does not enforce it
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  import gwsa_pkg::*;

  gwsa_cmd_t cmd;
  gwsa_sts_t sts;

  // Controller: walks the multiplier chain, skips the divider when the sample
  // is outside the ellipse or at zero distance, and runs the memory clear.
  gwsa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Datapath: angle scaling, radius test, exp lookup, gain and divide, then a
  // read-modify-write of the saturating Q32.16 score.
  gwsa_dp #(
    .POINT_COUNT     (POINT_COUNT),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // a strobe is never followed directly by another one
  `GWSA_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  // an accepted transfer makes the block busy
  `GWSA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // results come out only once the controller is back at idle
  `GWSA_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)

endmodule
